// ----- src/eida_pkg.sv -----
// Shared types, constants and codes for the identifier allocator.
package eida_pkg;

	// Sizing of the identifier space and of the component mask.
	localparam int MAX_IDS   = 1024;
	localparam int MAX_KINDS = 32;
	localparam int ID_W      = $clog2(MAX_IDS);
	localparam int CNT_W     = ID_W + 1;

	// Fixed widths of the transaction fields.
	localparam int ENT_W    = 10;
	localparam int COMP_W   = 5;
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;

	typedef logic [ID_W-1:0]      id_t;
	typedef logic [MAX_KINDS-1:0] mask_t;

	// Operation codes carried on the func field.
	typedef enum logic [FUNC_W-1:0] {
		OP_CREATE   = 3'd0,
		OP_DESTROY  = 3'd1,
		OP_ATTACH   = 3'd2,
		OP_DETACH   = 3'd3,
		OP_CONTAINS = 3'd4
	} op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_ALIVE = 2'd2
	} status_t;

	// Request from the execute stage to the free list.
	typedef struct packed {
		logic take;
		logic push;
		id_t  push_id;
	} fl_req_t;

	// What the free list offers to the next create.
	typedef struct packed {
		logic avail;
		id_t  id;
	} fl_stat_t;

	// Write port of the entity store.
	typedef struct packed {
		logic  alive_we;
		id_t   alive_addr;
		logic  alive_val;
		logic  mask_we;
		id_t   mask_addr;
		mask_t mask_val;
	} es_wr_t;

	// Read data of the entity store.
	typedef struct packed {
		logic  alive;
		mask_t mask;
	} es_rd_t;

endpackage

// ----- src/eida_free_list.sv -----
// Free identifier queue and fresh identifier counter.
module eida_free_list (
	input  logic                clk,
	input  logic                arst_n,
	input  eida_pkg::fl_req_t   req,
	output eida_pkg::fl_stat_t  stat
);

	logic [eida_pkg::ID_W-1:0]  queue_mem [eida_pkg::MAX_IDS];
	eida_pkg::id_t              head_q;
	eida_pkg::id_t              tail_q;
	logic [eida_pkg::CNT_W-1:0] count_q;
	logic [eida_pkg::CNT_W-1:0] fresh_q;
	eida_pkg::id_t              head_nxt;
	eida_pkg::id_t              rd_data_q;
	eida_pkg::id_t              fwd_data_q;
	logic                       fwd_q;
	logic                       q_nonempty;
	logic                       fresh_ok;
	logic                       pop;
	logic                       fresh_take;

	// Queue position increment with wrap at the depth.
	function automatic eida_pkg::id_t wrap_inc(input eida_pkg::id_t p);
		if (p == eida_pkg::ID_W'(eida_pkg::MAX_IDS - 1)) begin
			return '0;
		end
		return p + eida_pkg::ID_W'(1);
	endfunction

	// Source selection: the queue wins over the fresh counter.
	assign q_nonempty = (count_q != '0);
	assign fresh_ok   = (fresh_q < eida_pkg::CNT_W'(eida_pkg::MAX_IDS));
	assign pop        = req.take & q_nonempty;
	assign fresh_take = req.take & ~q_nonempty;
	assign head_nxt   = pop ? wrap_inc(head_q) : head_q;

	// Queue memory: one push port, head entry read every cycle.
	always_ff @(posedge clk) begin
		if (req.push) begin
			queue_mem[tail_q] <= req.push_id;
		end
		rd_data_q  <= queue_mem[head_nxt];
		fwd_data_q <= req.push_id;
	end

	// Positions, counters and the write-to-read bypass flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
			fwd_q   <= 1'b0;
		end else begin
			fwd_q <= req.push && (tail_q == head_nxt);
			if (pop) begin
				head_q <= head_nxt;
			end
			if (req.push) begin
				tail_q <= wrap_inc(tail_q);
			end
			if (req.push && !pop) begin
				count_q <= count_q + eida_pkg::CNT_W'(1);
			end else if (pop && !req.push) begin
				count_q <= count_q - eida_pkg::CNT_W'(1);
			end
			if (fresh_take) begin
				fresh_q <= fresh_q + eida_pkg::CNT_W'(1);
			end
		end
	end

	// Offer for the next create.
	assign stat.avail = q_nonempty | fresh_ok;
	assign stat.id    = q_nonempty ? (fwd_q ? fwd_data_q : rd_data_q)
	                               : fresh_q[eida_pkg::ID_W-1:0];

`ifndef SYNTHESIS
	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		req.take |-> stat.avail)
		else $error("identifier taken while none is available");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= eida_pkg::CNT_W'(eida_pkg::MAX_IDS))
		else $error("free queue count beyond depth");
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= eida_pkg::CNT_W'(eida_pkg::MAX_IDS))
		else $error("fresh counter beyond identifier space");
`endif

endmodule

// ----- src/eida_ent_store.sv -----
// Alive map and component mask memories with the clearing pass after reset.
module eida_ent_store (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  eida_pkg::id_t     rd_addr,
	input  eida_pkg::es_wr_t  wr,
	output eida_pkg::es_rd_t  rd,
	output logic              busy
);

	logic            alive_mem [eida_pkg::MAX_IDS];
	eida_pkg::mask_t mask_mem  [eida_pkg::MAX_IDS];
	logic            clr_q;
	eida_pkg::id_t   clr_cnt_q;
	logic            a_we;
	eida_pkg::id_t   a_addr;
	logic            a_val;
	logic            m_we;
	eida_pkg::id_t   m_addr;
	eida_pkg::mask_t m_val;
	logic            alive_rd_q;
	eida_pkg::mask_t mask_rd_q;
	logic            a_fwd_q;
	logic            m_fwd_q;
	logic            a_fwd_val_q;
	eida_pkg::mask_t m_fwd_val_q;

	// The clearing pass owns the write ports until it is done.
	assign a_we   = clr_q | wr.alive_we;
	assign a_addr = clr_q ? clr_cnt_q : wr.alive_addr;
	assign a_val  = clr_q ? 1'b0 : wr.alive_val;
	assign m_we   = clr_q | wr.mask_we;
	assign m_addr = clr_q ? clr_cnt_q : wr.mask_addr;
	assign m_val  = clr_q ? '0 : wr.mask_val;

	// Memories with registered reads at the incoming entity.
	always_ff @(posedge clk) begin
		if (a_we) begin
			alive_mem[a_addr] <= a_val;
		end
		if (m_we) begin
			mask_mem[m_addr] <= m_val;
		end
		if (rd_en) begin
			alive_rd_q  <= alive_mem[rd_addr];
			mask_rd_q   <= mask_mem[rd_addr];
			a_fwd_val_q <= a_val;
			m_fwd_val_q <= m_val;
		end
	end

	// Bypass flags and the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			a_fwd_q   <= 1'b0;
			m_fwd_q   <= 1'b0;
		end else begin
			if (rd_en) begin
				a_fwd_q <= a_we && (a_addr == rd_addr);
				m_fwd_q <= m_we && (m_addr == rd_addr);
			end
			if (clr_q) begin
				if (clr_cnt_q == eida_pkg::ID_W'(eida_pkg::MAX_IDS - 1)) begin
					clr_q <= 1'b0;
				end
				clr_cnt_q <= clr_cnt_q + eida_pkg::ID_W'(1);
			end
		end
	end

	// A write in the same cycle as the read takes precedence over stale data.
	assign rd.alive = a_fwd_q ? a_fwd_val_q : alive_rd_q;
	assign rd.mask  = m_fwd_q ? m_fwd_val_q : mask_rd_q;
	assign busy     = clr_q;

`ifndef SYNTHESIS
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> clr_cnt_q == '0)
		else $error("clearing pass ended before covering all entries");
	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !rd_en)
		else $error("entity store read during clearing pass");
`endif

endmodule

// ----- src/entity_id_allocator_with_masks.sv -----
// Top level of the identifier allocator with component masks.
// Usage:
//  - Request channel: func, entity and component with in_valid and in_stall.
//    A transaction is taken at a clock edge with in_valid high, in_stall low.
//  - Result channel: entity_id, status and present with out_valid and
//    out_stall; exactly one result transaction per request, in order.
//  - The request is registered and the memories are read in the same cycle;
//    the result register loads when the request stage moves on. One request
//    per cycle when out_stall is low and the clearing pass is done.
//  - Back-to-back requests on the same identifier are served through
//    write-to-read bypass paths of the mask, alive and free-queue memories.
//  - After reset the alive map and mask memory are swept to zero, one entry
//    a cycle: in_stall stays high after arst_n rises until every entry is cleared.
//  - When out_stall holds a result, the request stage keeps its transaction
//    and in_stall rises, so nothing is lost or repeated.
module entity_id_allocator_with_masks (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [eida_pkg::FUNC_W-1:0]   func,
	input  logic [eida_pkg::ENT_W-1:0]    entity,
	input  logic [eida_pkg::COMP_W-1:0]   component,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [eida_pkg::ENT_W-1:0]    entity_id,
	output logic [eida_pkg::STATUS_W-1:0] status,
	output logic                          present
);

	logic                          s1_vld_q;
	logic [eida_pkg::FUNC_W-1:0]   func_s1;
	logic [eida_pkg::ENT_W-1:0]    ent_s1;
	logic [eida_pkg::COMP_W-1:0]   comp_s1;
	logic                          out_vld_q;
	logic [eida_pkg::ENT_W-1:0]    entity_id_q;
	logic [eida_pkg::STATUS_W-1:0] status_q;
	logic                          present_q;
	logic                          accept;
	logic                          move;
	logic                          busy;
	logic                          ent_ok;
	logic                          comp_ok;
	eida_pkg::id_t                 ent_id_s1;
	eida_pkg::mask_t               bitv;
	eida_pkg::id_t                 id_nx;
	eida_pkg::status_t             st_nx;
	logic                          pr_nx;
	eida_pkg::fl_req_t             fl_req;
	eida_pkg::fl_stat_t            fl_stat;
	eida_pkg::es_wr_t              es_wr;
	eida_pkg::es_rd_t              es_rd;

	// Handshake: the request stage advances when the result slot frees up.
	assign move     = s1_vld_q & (~out_vld_q | ~out_stall);
	assign in_stall = busy | (s1_vld_q & ~move);
	assign accept   = in_valid & ~in_stall;

	eida_free_list u_free_list (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fl_req),
		.stat   (fl_stat)
	);

	eida_ent_store u_ent_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (eida_pkg::ID_W'(entity)),
		.wr      (es_wr),
		.rd      (es_rd),
		.busy    (busy)
	);

	// Request stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (move) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			ent_s1  <= entity;
			comp_s1 <= component;
		end
	end

	// Range checks and the selected component bit.
	assign ent_ok    = (int'(ent_s1) < eida_pkg::MAX_IDS);
	assign comp_ok   = (int'(comp_s1) < eida_pkg::MAX_KINDS);
	assign ent_id_s1 = eida_pkg::ID_W'(ent_s1);
	assign bitv      = eida_pkg::mask_t'(1) << comp_s1;

	// Execute one request; state updates fire only when it moves on.
	always_comb begin
		id_nx            = '0;
		st_nx            = eida_pkg::ST_OK;
		pr_nx            = 1'b0;
		fl_req           = '0;
		fl_req.push_id   = ent_id_s1;
		es_wr            = '0;
		es_wr.alive_addr = ent_id_s1;
		es_wr.mask_addr  = ent_id_s1;
		unique case (func_s1)
			eida_pkg::OP_CREATE: begin
				if (fl_stat.avail) begin
					id_nx            = fl_stat.id;
					fl_req.take      = move;
					es_wr.alive_we   = move;
					es_wr.alive_addr = fl_stat.id;
					es_wr.alive_val  = 1'b1;
				end else begin
					st_nx = eida_pkg::ST_FULL;
				end
			end
			eida_pkg::OP_DESTROY: begin
				if (!ent_ok || !es_rd.alive) begin
					st_nx = eida_pkg::ST_NOT_ALIVE;
				end else begin
					fl_req.push     = move;
					es_wr.alive_we  = move;
					es_wr.alive_val = 1'b0;
					es_wr.mask_we   = move;
					es_wr.mask_val  = '0;
				end
			end
			eida_pkg::OP_ATTACH: begin
				if (ent_ok && comp_ok) begin
					es_wr.mask_we  = move;
					es_wr.mask_val = es_rd.mask | bitv;
				end
			end
			eida_pkg::OP_DETACH: begin
				if (ent_ok && comp_ok) begin
					es_wr.mask_we  = move;
					es_wr.mask_val = es_rd.mask & ~bitv;
				end
			end
			eida_pkg::OP_CONTAINS: begin
				if (ent_ok && comp_ok) begin
					pr_nx = |(es_rd.mask & bitv);
				end
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (move) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			entity_id_q <= eida_pkg::ENT_W'(id_nx);
			status_q    <= st_nx;
			present_q   <= pr_nx;
		end
	end

	assign out_valid = out_vld_q;
	assign entity_id = entity_id_q;
	assign status    = status_q;
	assign present   = present_q;

`ifndef SYNTHESIS
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s1_vld_q && !out_vld_q)
		else $error("transaction in flight during clearing pass");
	a_move_loads: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_vld_q)
		else $error("result lost after request stage advanced");
`endif

endmodule

// ----- test/entity_id_allocator_with_masks_test.sv -----
// Self-checking regression of the identifier allocator with component masks.
module entity_id_allocator_with_masks_test;
	import eida_pkg::*;

	// Operation codes that the block does not use; they must answer all zero.
	localparam logic [FUNC_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] OP_SPARE_LAST  = 3'd7;

	// Cycles without any transaction before the run is declared hung.
	localparam int HANG_LIMIT  = 5000;
	localparam int DRAIN_TAIL  = 8;
	localparam int DIR_ROWS    = 23;

	typedef struct packed {
		id_t     entity_id;
		status_t status;
		logic    present;
	} result_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		id_t               ent;
		logic [COMP_W-1:0] comp;
		logic              typed;
		result_t           res;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [ENT_W-1:0]  entity = '0;
	logic [COMP_W-1:0] component = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ENT_W-1:0]  entity_id;
	logic [STATUS_W-1:0] status;
	logic              present;

	// Shadow copy of the allocator state.
	logic [CNT_W-1:0]  fresh_next;
	id_t               reuse_ring [MAX_IDS];
	id_t               ring_head;
	id_t               ring_tail;
	logic [CNT_W-1:0]  ring_count;
	logic              alive_bits [MAX_IDS];
	mask_t             kind_masks [MAX_IDS];
	id_t               live_ids [$];

	result_t           pending_results [$];
	stim_row_t         directed [DIR_ROWS];
	int                send_idle_pct = 28;
	int                recv_idle_pct = 55;
	int                errors = 0;
	int                hang_count = 0;
	int                op_seen [8];
	int                full_seen = 0;
	int                dead_seen = 0;
	int                hits_seen = 0;
	int                results_seen = 0;

	entity_id_allocator_with_masks uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.entity(entity),
		.component(component),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.entity_id(entity_id),
		.status(status),
		.present(present)
	);

	// Free-running clock, period of four.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Computes the answer to one request and advances the shadow state.
	function automatic result_t allocate_step(input logic [FUNC_W-1:0] f, input id_t e,
			input logic [COMP_W-1:0] c);
		result_t r;
		id_t     id;
		logic    ent_ok;
		logic    comp_ok;
		r = '{entity_id: '0, status: ST_OK, present: 1'b0};
		ent_ok = int'(e) < MAX_IDS;
		comp_ok = int'(c) < MAX_KINDS;
		case (f)
			OP_CREATE: begin
				if (ring_count != '0) begin
					id = reuse_ring[ring_head];
					ring_head = id_t'((int'(ring_head) + 1) % MAX_IDS);
					ring_count = ring_count - CNT_W'(1);
					alive_bits[id] = 1'b1;
					live_ids = {live_ids, id};
					r.entity_id = id;
				end else if (int'(fresh_next) < MAX_IDS) begin
					id = id_t'(fresh_next);
					fresh_next = fresh_next + CNT_W'(1);
					alive_bits[id] = 1'b1;
					live_ids = {live_ids, id};
					r.entity_id = id;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_DESTROY: begin
				if (!ent_ok || !alive_bits[e]) begin
					r.status = ST_NOT_ALIVE;
				end else begin
					kind_masks[e] = '0;
					alive_bits[e] = 1'b0;
					reuse_ring[ring_tail] = e;
					ring_tail = id_t'((int'(ring_tail) + 1) % MAX_IDS);
					ring_count = ring_count + CNT_W'(1);
					foreach (live_ids[i]) begin
						if (live_ids[i] == e) begin
							live_ids.delete(i);
							break;
						end
					end
				end
			end
			OP_ATTACH: begin
				if (ent_ok && comp_ok)
					kind_masks[e][c] = 1'b1;
			end
			OP_DETACH: begin
				if (ent_ok && comp_ok)
					kind_masks[e][c] = 1'b0;
			end
			OP_CONTAINS: begin
				if (ent_ok && comp_ok)
					r.present = kind_masks[e][c];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Offers one request, waits for its acceptance and records what it should return.
	task automatic send_request(input logic [FUNC_W-1:0] f, input id_t e,
			input logic [COMP_W-1:0] c, input logic typed, input result_t typed_res);
		result_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		entity <= e;
		component <= c;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		predicted = allocate_step(f, e, c);
		op_seen[f] = op_seen[f] + 1;
		if (predicted.status == ST_FULL)
			full_seen = full_seen + 1;
		if (predicted.status == ST_NOT_ALIVE)
			dead_seen = dead_seen + 1;
		if (predicted.present)
			hits_seen = hits_seen + 1;
		if (typed)
			predicted = typed_res;
		pending_results = {pending_results, predicted};
	endtask

	// Draws one random request; create_pct sets how often it is a create.
	task automatic send_random(input int create_pct);
		logic [FUNC_W-1:0] f;
		id_t               e;
		logic [COMP_W-1:0] c;
		int                pick;
		result_t           unused_res;
		unused_res = '0;
		e = id_t'($urandom_range(MAX_IDS - 1));
		c = COMP_W'($urandom_range((1 << COMP_W) - 1));
		pick = $urandom_range(99);
		if ($urandom_range(99) < create_pct) begin
			f = OP_CREATE;
		end else if (pick < 20) begin
			f = OP_DESTROY;
		end else if (pick < 45) begin
			f = OP_ATTACH;
		end else if (pick < 65) begin
			f = OP_DETACH;
		end else if (pick < 93) begin
			f = OP_CONTAINS;
		end else begin
			f = FUNC_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
		end
		// Mostly operate on identifiers that are alive, so the masks fill up.
		if (live_ids.size() != 0 && $urandom_range(99) < 80)
			e = live_ids[$urandom_range(live_ids.size() - 1)];
		send_request(f, e, c, 1'b0, unused_res);
	endtask

	// Holds off the request side until every outstanding result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stall and in-order comparison.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing outstanding: id %0d status %0d present %0d",
					$time, entity_id, status, present);
				errors = errors + 1;
			end else begin
				if (pending_results[0].entity_id !== entity_id) begin
					$display("%0t: entity_id expected %0d actual %0d", $time,
						pending_results[0].entity_id, entity_id);
					errors = errors + 1;
				end
				if (pending_results[0].status !== status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						pending_results[0].status, status);
					errors = errors + 1;
				end
				if (pending_results[0].present !== present) begin
					$display("%0t: present expected %0d actual %0d", $time,
						pending_results[0].present, present);
					errors = errors + 1;
				end
				void'(pending_results.pop_front());
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Hang detection: counts cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			hang_count <= 0;
		else
			hang_count <= hang_count + 1;
		if (hang_count >= HANG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
			$display("entity_id_allocator_with_masks regression: fail");
			$finish;
		end
	end

	initial begin
		fresh_next = '0;
		ring_head = '0;
		ring_tail = '0;
		ring_count = '0;
		foreach (alive_bits[i]) begin
			alive_bits[i] = 1'b0;
			kind_masks[i] = '0;
			reuse_ring[i] = '0;
		end
		foreach (op_seen[i])
			op_seen[i] = 0;

		// Directed requests; rows marked typed carry an answer read off by hand.
		directed = '{
			'{OP_CONTAINS, 10'd0, 5'd0, 1'b1, '{10'd0, ST_OK, 1'b0}},
			'{OP_DESTROY, 10'd0, 5'd0, 1'b1, '{10'd0, ST_NOT_ALIVE, 1'b0}},
			'{OP_DESTROY, 10'd1023, 5'd31, 1'b1, '{10'd0, ST_NOT_ALIVE, 1'b0}},
			'{OP_CREATE, 10'd1023, 5'd31, 1'b1, '{10'd0, ST_OK, 1'b0}},
			'{OP_CREATE, 10'd0, 5'd0, 1'b1, '{10'd1, ST_OK, 1'b0}},
			'{OP_ATTACH, 10'd0, 5'd0, 1'b0, '{10'd0, ST_OK, 1'b0}},
			'{OP_ATTACH, 10'd0, 5'd31, 1'b0, '{10'd0, ST_OK, 1'b0}},
			'{OP_CONTAINS, 10'd0, 5'd31, 1'b1, '{10'd0, ST_OK, 1'b1}},
			'{OP_CONTAINS, 10'd0, 5'd0, 1'b1, '{10'd0, ST_OK, 1'b1}},
			'{OP_CONTAINS, 10'd0, 5'd1, 1'b0, '{10'd0, ST_OK, 1'b0}},
			'{OP_DETACH, 10'd0, 5'd31, 1'b0, '{10'd0, ST_OK, 1'b0}},
			'{OP_CONTAINS, 10'd0, 5'd31, 1'b0, '{10'd0, ST_OK, 1'b0}},
			// Mask operations on an identifier that was never created.
			'{OP_ATTACH, 10'd1023, 5'd31, 1'b0, '{10'd0, ST_OK, 1'b0}},
			'{OP_CONTAINS, 10'd1023, 5'd31, 1'b1, '{10'd0, ST_OK, 1'b1}},
			'{OP_SPARE_FIRST, 10'd1023, 5'd31, 1'b1, '{10'd0, ST_OK, 1'b0}},
			'{OP_SPARE_LAST, 10'd1023, 5'd31, 1'b1, '{10'd0, ST_OK, 1'b0}},
			// Destroy clears the mask and queues the identifier for reuse.
			'{OP_DESTROY, 10'd0, 5'd0, 1'b1, '{10'd0, ST_OK, 1'b0}},
			'{OP_CONTAINS, 10'd0, 5'd0, 1'b1, '{10'd0, ST_OK, 1'b0}},
			'{OP_DESTROY, 10'd0, 5'd0, 1'b1, '{10'd0, ST_NOT_ALIVE, 1'b0}},
			'{OP_CREATE, 10'd0, 5'd0, 1'b1, '{10'd0, ST_OK, 1'b0}},
			'{OP_CREATE, 10'd0, 5'd0, 1'b1, '{10'd2, ST_OK, 1'b0}},
			'{OP_DETACH, 10'd1023, 5'd31, 1'b0, '{10'd0, ST_OK, 1'b0}},
			'{OP_CONTAINS, 10'd1023, 5'd31, 1'b0, '{10'd0, ST_OK, 1'b0}}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i].func, directed[i].ent, directed[i].comp,
				directed[i].typed, directed[i].res);

		// Mixed traffic with a slow sender and a slower receiver.
		repeat (250) send_random(25);
		drain_results();

		send_idle_pct = 55;
		recv_idle_pct = 28;
		repeat (250) send_random(25);
		drain_results();

		// Full rate: mostly creates, so a large part of the identifier space is alive.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (230) send_random(85);

		// Churn with many live identifiers so freed ones come back out of the queue.
		repeat (200) send_random(30);

		drain_results();
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("Ran %0d creates, %0d destroys, %0d attaches, %0d detaches, %0d lookups",
			op_seen[OP_CREATE], op_seen[OP_DESTROY], op_seen[OP_ATTACH],
			op_seen[OP_DETACH], op_seen[OP_CONTAINS]);
		$display("Saw %0d exhausted creates, %0d bad destroys, %0d hits, %0d results checked",
			full_seen, dead_seen, hits_seen, results_seen);
		if (errors == 0)
			$display("entity_id_allocator_with_masks regression: pass");
		else
			$display("entity_id_allocator_with_masks regression: fail");
		$finish;
	end

endmodule
